// ===== rtl/core/tfrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfrb_pkg
// Shared types and constants of the terminated frame ring buffer.
// ----------------------------------------------------------------------------
package tfrb_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RECV  = 2'd0,
    OP_POLL  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    KIND_POLL  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLL_RD,
    S_POLL_CHK,
    S_POLL_ANS,
    S_FETCH_RD,
    S_FETCH_LOAD
  } state_t;

endpackage

// ===== rtl/core/tfrb_ram.sv =====
// ----------------------------------------------------------------------------
// tfrb_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tfrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/terminated_frame_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// terminated_frame_ring_buffer_unit
// Circular byte store with zero as the empty mark; poll counts a frame,
// fetch streams it out and clears the slots.
// ----------------------------------------------------------------------------
// Receive: written from idle. Poll: each slot is read, then checked, until an
// empty slot or a count of BUFFER_DEPTH, then the answer loads; fetch: each
// byte is read, then loaded, paced by the registered RAM read. One item at a time.
// A result waits in the output register; out_tready low stalls the walk.
// Reset (synchronous, rst_n low) clears positions, counts and slot valid bits.
// ----------------------------------------------------------------------------
module terminated_frame_ring_buffer_unit #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: terminator
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] frame_length, [14:7] data_byte, [15] zero
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  function automatic logic [AW-1:0] nxt_pos(input logic [AW-1:0] p);
    return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  tfrb_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [AW-1:0] scan_pos_r, scan_pos_nxt;
  logic [AW-1:0] rd_pos_r, rd_pos_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          done_r, done_nxt;
  logic [7:0]    term_r, term_nxt;
  logic [BUFFER_DEPTH-1:0] slot_vld_r, slot_vld_nxt;
  logic          vld_q_r;

  logic          out_vld_r, out_vld_nxt;
  logic          out_load;
  tfrb_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [tfrb_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [tfrb_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    slot_byte;
  logic          out_free;
  tfrb_pkg::op_t in_op;

  tfrb_ram #(
    .WIDTH (tfrb_pkg::DATA_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_pos_r),
    .wr_data (in_tdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_op     = tfrb_pkg::op_t'(in_tuser);
  assign slot_byte = vld_q_r ? ram_rdata : 8'd0;
  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == tfrb_pkg::S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    wr_pos_nxt   = wr_pos_r;
    scan_pos_nxt = scan_pos_r;
    rd_pos_nxt   = rd_pos_r;
    pend_nxt     = pend_r;
    rem_nxt      = rem_r;
    done_nxt     = done_r;
    term_nxt     = cfg_wr_en ? cfg_wr_data : term_r;
    slot_vld_nxt = slot_vld_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = scan_pos_r;
    out_load     = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_len_nxt  = out_len_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;

    case (state_r)
      tfrb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            tfrb_pkg::OP_RECV: begin
              ram_we                 = 1'b1;
              slot_vld_nxt[wr_pos_r] = 1'b1;
              wr_pos_nxt             = nxt_pos(wr_pos_r);
            end
            tfrb_pkg::OP_POLL: begin
              if (done_r) begin
                pend_nxt = '0;
              end
              done_nxt  = 1'b0;
              state_nxt = tfrb_pkg::S_POLL_RD;
            end
            tfrb_pkg::OP_FETCH: begin
              if (pend_r == '0) begin
                rd_pos_nxt = scan_pos_r;
              end else begin
                rem_nxt   = pend_r;
                state_nxt = tfrb_pkg::S_FETCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      tfrb_pkg::S_POLL_RD: begin
        if (pend_r == CW'(BUFFER_DEPTH)) begin
          state_nxt = tfrb_pkg::S_POLL_ANS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_pos_r;
          state_nxt = tfrb_pkg::S_POLL_CHK;
        end
      end
      tfrb_pkg::S_POLL_CHK: begin
        if (slot_byte != 8'd0) begin
          pend_nxt = pend_r + 1'b1;
          if (slot_byte == term_r) begin
            done_nxt = 1'b1;
          end
          scan_pos_nxt = nxt_pos(scan_pos_r);
          state_nxt    = tfrb_pkg::S_POLL_RD;
        end else begin
          state_nxt = tfrb_pkg::S_POLL_ANS;
        end
      end
      tfrb_pkg::S_POLL_ANS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = tfrb_pkg::KIND_POLL;
          out_data_nxt = '0;
          out_last_nxt = 1'b1;
          if (done_r) begin
            out_len_nxt = tfrb_pkg::LEN_W'(pend_r);
          end else if (pend_r != '0 && term_r == 8'd0) begin
            done_nxt    = 1'b1;
            out_len_nxt = tfrb_pkg::LEN_W'(pend_r);
          end else begin
            out_len_nxt = '0;
          end
          state_nxt = tfrb_pkg::S_IDLE;
        end
      end
      tfrb_pkg::S_FETCH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rd_pos_r;
        state_nxt = tfrb_pkg::S_FETCH_LOAD;
      end
      tfrb_pkg::S_FETCH_LOAD: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_kind_nxt           = tfrb_pkg::KIND_FETCH;
          out_len_nxt            = tfrb_pkg::LEN_W'(pend_r);
          out_data_nxt           = slot_byte;
          out_last_nxt           = (rem_r == CW'(1));
          slot_vld_nxt[rd_pos_r] = 1'b0;
          rem_nxt                = rem_r - 1'b1;
          if (rem_r == CW'(1)) begin
            rd_pos_nxt = scan_pos_r;
            pend_nxt   = '0;
            state_nxt  = tfrb_pkg::S_IDLE;
          end else begin
            rd_pos_nxt = nxt_pos(rd_pos_r);
            state_nxt  = tfrb_pkg::S_FETCH_RD;
          end
        end
      end
      default: begin
        state_nxt = tfrb_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tfrb_pkg::S_IDLE;
      wr_pos_r   <= '0;
      scan_pos_r <= '0;
      rd_pos_r   <= '0;
      pend_r     <= '0;
      rem_r      <= '0;
      done_r     <= 1'b1;
      term_r     <= 8'd0;
      slot_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_pos_r   <= wr_pos_nxt;
      scan_pos_r <= scan_pos_nxt;
      rd_pos_r   <= rd_pos_nxt;
      pend_r     <= pend_nxt;
      rem_r      <= rem_nxt;
      done_r     <= done_nxt;
      term_r     <= term_nxt;
      slot_vld_r <= slot_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      vld_q_r <= slot_vld_r[ram_raddr];
    end
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_data_r, out_len_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CW'(BUFFER_DEPTH))
    else $error("pending count beyond store depth");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfrb_pkg::S_POLL_CHK) |-> ($past(state_r) == tfrb_pkg::S_POLL_RD))
    else $error("slot checked without a read issued");

  a_fetch_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfrb_pkg::S_FETCH_LOAD && out_free && rem_r == CW'(1))
      |=> (pend_r == '0 && rd_pos_r == scan_pos_r))
    else $error("fetch end left count or read position stale");

endmodule

// ===== tb/sv/tb_terminated_frame_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_terminated_frame_ring_buffer_unit
// Self-checking bench for the terminated frame ring buffer. A queue of
// receive, poll and fetch beats, with terminator changes between phases,
// feeds a driver on the input stream. A cycle-free predictor of the ring
// store computes every poll answer and fetched byte. A monitor compares each
// result beat with the oldest prediction. Both streams idle in random bursts.
// ----------------------------------------------------------------------------
module tb_terminated_frame_ring_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = 64;
  localparam int          SETTLE_CYCLES  = 2 * DEPTH + 32;
  localparam int          TARGET_BEATS   = 330;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  typedef enum logic [0:0] {
    ENTRY_BEAT,
    ENTRY_TERM
  } entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic [1:0]  op;
    logic [7:0]  data;
    bit          calm;
  } entry_t;

  typedef struct {
    tfrb_pkg::kind_t kind;
    logic [6:0]  len;
    logic [7:0]  data;
    logic        last;
  } out_beat_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic [1:0]  in_tuser    = 2'd0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  terminated_frame_ring_buffer_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ring store predictor
  logic [7:0] ring_store [DEPTH];
  logic [5:0] wr_slot     = '0;
  logic [5:0] scan_slot   = '0;
  logic [5:0] rd_slot     = '0;
  logic [6:0] held_count  = '0;
  logic       frame_closed = 1'b1;
  logic [7:0] term_byte   = 8'h00;

  entry_t    stim_q[$];
  out_beat_t due_beats[$];

  logic in_took = 1'b0;
  bit   calm    = 1'b0;
  int   in_gap  = 0;
  int   out_gap = 0;
  int   settle  = 0;

  int beat_total    = 0;
  int error_count   = 0;
  int poll_answers  = 0;
  int frames_found  = 0;
  int fetched_bytes = 0;
  int cfg_writes    = 0;

  initial begin
    foreach (ring_store[i]) ring_store[i] = 8'h00;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("tb_terminated_frame_ring_buffer_unit: FAIL");
    $finish;
  end

  function automatic void model_beat(input logic [1:0] op, input logic [7:0] b);
    out_beat_t  ob;
    logic [6:0] answer;
    logic [6:0] n;
    if (op == tfrb_pkg::OP_RECV) begin
      ring_store[wr_slot] = b;
      wr_slot++;
    end else if (op == tfrb_pkg::OP_POLL) begin
      if (frame_closed) held_count = '0;
      frame_closed = 1'b0;
      while (ring_store[scan_slot] != 8'h00 && held_count < DEPTH) begin
        held_count++;
        if (ring_store[scan_slot] == term_byte) frame_closed = 1'b1;
        scan_slot++;
      end
      answer = '0;
      if (frame_closed) begin
        answer = held_count;
      end else if (held_count != 0 && term_byte == 8'h00) begin
        frame_closed = 1'b1;
        answer = held_count;
      end
      ob.kind = tfrb_pkg::KIND_POLL;
      ob.len  = answer;
      ob.data = 8'h00;
      ob.last = 1'b1;
      due_beats.push_back(ob);
    end else if (op == tfrb_pkg::OP_FETCH) begin
      n = held_count;
      for (int i = 0; i < n; i++) begin
        ob.kind = tfrb_pkg::KIND_FETCH;
        ob.len  = n;
        ob.data = ring_store[rd_slot];
        ob.last = (i + 1 == n);
        due_beats.push_back(ob);
        ring_store[rd_slot] = 8'h00;
        rd_slot++;
      end
      rd_slot    = scan_slot;
      held_count = '0;
    end
  endfunction

  function automatic void flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", what);
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    logic   nxt_valid;
    logic   nxt_cfg;
    entry_t head;
    nxt_valid = in_tvalid;
    nxt_cfg   = 1'b0;
    if (rst_n && !(in_tvalid && !in_took)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (stim_q.size() != 0) begin
        head = stim_q[0];
        if (head.kind == ENTRY_TERM) begin
          if (due_beats.size() != 0) begin
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            settle = 0;
            nxt_cfg = 1'b1;
            cfg_wr_data <= head.data;
            term_byte = head.data;
            cfg_writes++;
            void'(stim_q.pop_front());
          end
        end else begin
          void'(stim_q.pop_front());
          nxt_valid = 1'b1;
          in_tuser <= head.op;
          in_tdata <= head.data;
          calm     <= head.calm;
          if (!head.calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 17);
        end
      end
    end
    in_tvalid <= nxt_valid;
    cfg_wr_en <= nxt_cfg;
  end

  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap   = $urandom_range(1, 17) - 1;
      nxt_ready = 1'b0;
    end
    out_tready <= nxt_ready;
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    out_beat_t exp_b;
    out_beat_t got_b;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) model_beat(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got_b.kind = tfrb_pkg::kind_t'(out_tuser[0]);
        got_b.len  = out_tdata[6:0];
        got_b.data = out_tdata[14:7];
        got_b.last = out_tlast;
        if (got_b.kind == tfrb_pkg::KIND_POLL) begin
          poll_answers++;
          if (got_b.len != 0) frames_found++;
        end else begin
          fetched_bytes++;
        end
        if (due_beats.size() == 0) begin
          flag_error($sformatf("unexpected beat: kind=%0d len=%0d data=%h last=%0b",
                               got_b.kind, got_b.len, got_b.data, got_b.last));
        end else begin
          exp_b = due_beats.pop_front();
          if (got_b.kind !== exp_b.kind || got_b.len !== exp_b.len ||
              got_b.data !== exp_b.data || got_b.last !== exp_b.last) begin
            flag_error($sformatf(
              {"mismatch: exp kind=%0d len=%0d data=%h last=%0b, ",
               "got kind=%0d len=%0d data=%h last=%0b"},
              exp_b.kind, exp_b.len, exp_b.data, exp_b.last,
              got_b.kind, got_b.len, got_b.data, got_b.last));
          end
        end
      end
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [7:0] b, input bit quiet);
    entry_t e;
    e.kind = ENTRY_BEAT;
    e.op   = op;
    e.data = b;
    e.calm = quiet;
    stim_q.push_back(e);
    if (op != OP_UNUSED) beat_total++;
  endtask

  task automatic push_term(input logic [7:0] value);
    entry_t e;
    e.kind = ENTRY_TERM;
    e.op   = tfrb_pkg::OP_RECV;
    e.data = value;
    e.calm = 1'b0;
    stim_q.push_back(e);
  endtask

  function automatic logic [7:0] body_byte(input logic [7:0] term);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == term);
    return b;
  endfunction

  task automatic push_frame(input logic [7:0] term, input int len, input bit quiet);
    for (int i = 0; i < len - 1; i++) push_beat(tfrb_pkg::OP_RECV, body_byte(term), quiet);
    push_beat(tfrb_pkg::OP_RECV, (term != 8'h00) ? term : body_byte(term), quiet);
  endtask

  function automatic logic [7:0] pick_term();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0A;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  task automatic push_phase(input bit quiet);
    logic [7:0] term;
    int         frames;
    int         len;
    int         split;
    term   = pick_term();
    frames = $urandom_range(2, 6);
    push_term(term);
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), quiet);
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      if (len > 1 && $urandom_range(0, 4) == 0) begin
        split = $urandom_range(1, len - 1);
        for (int i = 0; i < split; i++)
          push_beat(tfrb_pkg::OP_RECV, body_byte(term), quiet);
        push_beat(tfrb_pkg::OP_POLL, 8'($urandom_range(0, 255)), quiet);
        push_frame(term, len - split, quiet);
      end else begin
        push_frame(term, len, quiet);
      end
      push_beat(tfrb_pkg::OP_POLL, 8'($urandom_range(0, 255)), quiet);
      if ($urandom_range(0, 3) == 0) push_beat(tfrb_pkg::OP_POLL, 8'h00, quiet);
      if ($urandom_range(0, 7) != 0)
        push_beat(tfrb_pkg::OP_FETCH, 8'($urandom_range(0, 255)), quiet);
    end
  endtask

  initial begin
    // empty store, nothing counted, unused code, any-data frame
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'hFF, 1'b0);
    push_beat(OP_UNUSED, 8'hA5, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'hFF, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'h01, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    // partial count kept, then completed; fetch before completion
    push_term(8'h0A);
    push_beat(tfrb_pkg::OP_RECV, 8'h41, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'h0A, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'h33, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'h00, 1'b0);
    push_term(8'hFF);
    push_beat(tfrb_pkg::OP_RECV, 8'h80, 1'b0);
    push_beat(tfrb_pkg::OP_RECV, 8'hFF, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'h00, 1'b0);
    // fill every slot with no terminator: the walk stops at the depth
    for (int i = 0; i < DEPTH; i++)
      push_beat(tfrb_pkg::OP_RECV, 8'($urandom_range(1, 254)), 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_POLL, 8'h00, 1'b0);
    push_beat(tfrb_pkg::OP_FETCH, 8'h00, 1'b0);

    while (beat_total < TARGET_BEATS) push_phase(1'b0);
    push_phase(1'b1);

    while (!rst_n) @(negedge clk);
    while (stim_q.size() != 0 || (in_tvalid && !in_took) || due_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d input beats and %0d terminator writes", beat_total, cfg_writes);
    $display("checked %0d poll answers (%0d frames found) and %0d fetched bytes",
             poll_answers, frames_found, fetched_bytes);
    if (error_count == 0) begin
      $display("tb_terminated_frame_ring_buffer_unit: PASS");
    end else begin
      $display("%0d errors", error_count);
      $display("tb_terminated_frame_ring_buffer_unit: FAIL");
    end
    $finish;
  end

endmodule
